FILE: rtl/arbc_pkg.sv
// Shared types, constants and border-check functions for the rectangle border check block.
package arbc_pkg;

  // Matrix geometry: index fields are four bits wide, so the matrix is 16 x 16
  localparam int IdxW       = 4;
  localparam int MatrixSize = 1 << IdxW;

  // Stream widths
  localparam int InTdataW  = 32;
  localparam int InTuserW  = 2;
  localparam int OutTdataW = 8;

  typedef logic [IdxW-1:0]       idx_t;
  typedef logic [MatrixSize-1:0] word_t;

  // Item kinds; the fourth code is unused and does nothing
  typedef enum logic [InTuserW-1:0] {
    CmdClear = 2'd0,
    CmdWrite = 2'd1,
    CmdQuery = 2'd2
  } cmd_e;

  // Update request towards the matrix store
  typedef struct packed {
    logic clr;
    logic we;
    idx_t row;
    idx_t col;
    logic cell_val;
  } mat_wr_t;

  // Queried rectangle
  typedef struct packed {
    idx_t row_first;
    idx_t row_last;
    idx_t col_first;
    idx_t col_last;
  } rect_t;

  // Ones from first to last inclusive; empty when the span is reversed
  function automatic word_t span_mask(idx_t first, idx_t last);
    word_t upto;
    word_t from;
    upto = {MatrixSize{1'b1}} >> (idx_t'(MatrixSize - 1) - last);
    from = {MatrixSize{1'b1}} << first;
    return (first <= last) ? (upto & from) : '0;
  endfunction

  // All set cells of the word lie inside the span, and at least one does
  function automatic logic border_ok(word_t w, word_t m);
    return ((w & m) != '0) && ((w & ~m) == '0);
  endfunction

endpackage

FILE: rtl/arbc_matrix.sv
// Alignment matrix store: clear, single-cell update and row/column read-out.
module arbc_matrix (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  arbc_pkg::mat_wr_t wr_i,
  input  arbc_pkg::rect_t   rect_i,
  output arbc_pkg::word_t   row_first_o,
  output arbc_pkg::word_t   row_last_o,
  output arbc_pkg::word_t   col_first_o,
  output arbc_pkg::word_t   col_last_o
);
  import arbc_pkg::*;

  // Row r, bit c holds cell (r,c)
  word_t [MatrixSize-1:0] row_q;
  word_t [MatrixSize-1:0] row_d;

  // Apply clear or single-cell update
  always_comb begin
    row_d = row_q;
    if (wr_i.clr) begin
      row_d = '0;
    end else if (wr_i.we) begin
      row_d[wr_i.row][wr_i.col] = wr_i.cell_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  // Read the border rows directly
  assign row_first_o = row_q[rect_i.row_first];
  assign row_last_o  = row_q[rect_i.row_last];

  // Gather the border columns across all rows
  always_comb begin
    for (int r = 0; r < MatrixSize; r++) begin
      col_first_o[r] = row_q[r][rect_i.col_first];
      col_last_o[r]  = row_q[r][rect_i.col_last];
    end
  end

  // A clear empties the whole matrix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.clr |=> (row_q == '0))
    else $error("matrix not empty after clear");

  // An update lands the written value in the addressed cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i.we && !wr_i.clr) |=>
      (row_q[$past(wr_i.row)][$past(wr_i.col)] == $past(wr_i.cell_val)))
    else $error("cell update lost");

  // An update touches at most one cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i.we && !wr_i.clr) |=> ($countones(row_q ^ $past(row_q)) <= 1))
    else $error("cell update disturbed other cells");

endmodule

FILE: rtl/arbc_border.sv
// Four-sided border check of a queried rectangle against its border rows and columns.
module arbc_border (
  input  arbc_pkg::rect_t rect_i,
  input  arbc_pkg::word_t row_first_i,
  input  arbc_pkg::word_t row_last_i,
  input  arbc_pkg::word_t col_first_i,
  input  arbc_pkg::word_t col_last_i,
  output logic            ok_o
);
  import arbc_pkg::*;

  word_t col_mask;
  word_t row_mask;

  // Build the column span for the rows and the row span for the columns
  assign col_mask = span_mask(rect_i.col_first, rect_i.col_last);
  assign row_mask = span_mask(rect_i.row_first, rect_i.row_last);

  // Every border must be non-empty and fully inside its span
  assign ok_o = border_ok(row_first_i, col_mask)
             && border_ok(row_last_i,  col_mask)
             && border_ok(col_first_i, row_mask)
             && border_ok(col_last_i,  row_mask);

endmodule

FILE: rtl/align_rectangle_border_check.sv
// Top level of the rectangle border check: input register, matrix, check and result register.
//
// Usage
//   Slave stream: s_axis_tuser carries the item kind (clear, write, query);
//   s_axis_tdata carries the write cell and the query rectangle. Master
//   stream: one beat per query, m_axis_tdata bit 0 is the rectangle flag.
//   Clear and write items produce no output beat.
// Timing
//   An accepted beat is held in the input register while the matrix is read
//   and the border check runs; as the beat leaves the input register the
//   update is applied and a query flag enters the result register. The flag
//   is offered on m_axis from the result register. One item per cycle is
//   sustained while the master side does not stall; it rests on the single
//   combinational pass from input register to matrix update and result register.
// Reset
//   rst_ni empties the matrix and both registers; no beat is offered.
// Back-pressure
//   While a flag waits on m_axis, one further beat is still taken into the
//   input register; s_axis_tready drops only when both registers are full.
module align_rectangle_border_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [3:0] row_index, [7:4] col_index, [8] cell_bit, [12:9] rect_row_first,
  // [16:13] rect_row_last, [20:17] rect_col_first, [24:21] rect_col_last
  input  logic [arbc_pkg::InTdataW-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  logic [arbc_pkg::InTuserW-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] rect_valid
  output logic [arbc_pkg::OutTdataW-1:0] m_axis_tdata
);
  import arbc_pkg::*;

  // Input register
  logic                s1_vld_q, s1_vld_d;
  logic [InTuserW-1:0] s1_cmd_q;
  idx_t                s1_row_q, s1_col_q;
  logic                s1_cell_q;
  rect_t               s1_rect_q;

  // Result register
  logic out_vld_q, out_vld_d;
  logic out_flag_q;

  logic    in_acc;
  logic    adv;
  logic    is_clr, is_wr, is_qry;
  mat_wr_t mat_wr;
  word_t   row_first, row_last, col_first, col_last;
  logic    rect_ok;

  // Advance the held beat when the result register is free or being drained
  assign adv           = s1_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !s1_vld_q || adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (in_acc) begin
      s1_vld_d = 1'b1;
    end else if (adv) begin
      s1_vld_d = 1'b0;
    end else begin
      s1_vld_d = s1_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  // Capture the beat payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q            <= s_axis_tuser;
      s1_row_q            <= s_axis_tdata[3:0];
      s1_col_q            <= s_axis_tdata[7:4];
      s1_cell_q           <= s_axis_tdata[8];
      s1_rect_q.row_first <= s_axis_tdata[12:9];
      s1_rect_q.row_last  <= s_axis_tdata[16:13];
      s1_rect_q.col_first <= s_axis_tdata[20:17];
      s1_rect_q.col_last  <= s_axis_tdata[24:21];
    end
  end

  // Decode the item kind
  always_comb begin
    is_clr = 1'b0;
    is_wr  = 1'b0;
    is_qry = 1'b0;
    unique case (s1_cmd_q)
      CmdClear: is_clr = 1'b1;
      CmdWrite: is_wr  = 1'b1;
      CmdQuery: is_qry = 1'b1;
      default:  ;
    endcase
  end

  // Commit updates only as the beat leaves the input register
  assign mat_wr.clr      = adv && is_clr;
  assign mat_wr.we       = adv && is_wr;
  assign mat_wr.row      = s1_row_q;
  assign mat_wr.col      = s1_col_q;
  assign mat_wr.cell_val = s1_cell_q;

  arbc_matrix u_matrix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (mat_wr),
    .rect_i      (s1_rect_q),
    .row_first_o (row_first),
    .row_last_o  (row_last),
    .col_first_o (col_first),
    .col_last_o  (col_last)
  );

  arbc_border u_border (
    .rect_i      (s1_rect_q),
    .row_first_i (row_first),
    .row_last_i  (row_last),
    .col_first_i (col_first),
    .col_last_i  (col_last),
    .ok_o        (rect_ok)
  );

  // Load a query flag, drop a delivered one
  always_comb begin
    if (adv) begin
      out_vld_d = is_qry;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && is_qry) begin
      out_flag_q <= rect_ok;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutTdataW - 1){1'b0}}, out_flag_q};

  // Input stalls only with both registers full and the output held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_vld_q && out_vld_q && !m_axis_tready))
    else $error("input stalled without cause");

  // A query leaving the input register yields a result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && is_qry) |=> out_vld_q)
    else $error("query result missing");

  // Clear and write items never produce a result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !is_qry) |=> !out_vld_q)
    else $error("result beat without a query");

endmodule

FILE: dv/tb.sv
// Stream-level testbench for the rectangle border check: matrix predictor and flag scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import arbc_pkg::*;

  localparam logic [InTuserW-1:0] CmdUnused = 2'd3;
  localparam int NumItems   = 1100;
  localparam int CycleLimit = 200000;
  localparam int IdlePct    = 28;
  localparam int QuietFrom  = 700;
  localparam int QuietTo    = 1300;

  // One input beat, split into its fields
  typedef struct {
    logic [InTuserW-1:0] cmd;
    idx_t                row;
    idx_t                col;
    logic                cell_val;
    rect_t               rect;
  } matrix_op_t;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic [InTuserW-1:0]  s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  matrix_op_t op_queue[$];
  logic       awaited_flags[$];
  matrix_op_t op_on_bus;
  word_t      model_rows[MatrixSize];
  int         op_count    = 0;
  int         cycle_count = 0;
  int         fail_count  = 0;

  align_rectangle_border_check dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic quiet_window();
    return (cycle_count >= QuietFrom) && (cycle_count < QuietTo);
  endfunction

  // Ones from first to last inclusive, none when reversed
  function automatic word_t covered_cells(idx_t first, idx_t last);
    word_t m;
    m = '0;
    if (first <= last) begin
      for (int i = first; i <= last; i++) m[i] = 1'b1;
    end
    return m;
  endfunction

  // A border passes when its set cells are all inside the span and at least one exists
  function automatic logic border_holds(word_t w, word_t span);
    int in_span;
    in_span = $countones(w & span);
    return (in_span > 0) && (in_span == $countones(w));
  endfunction

  function automatic word_t column_word(idx_t c);
    word_t w;
    for (int r = 0; r < MatrixSize; r++) w[r] = model_rows[r][c];
    return w;
  endfunction

  // Apply one accepted beat to the model matrix; queries yield the expected flag
  task automatic apply_to_matrix(matrix_op_t op);
    word_t col_span;
    word_t row_span;
    logic  flag;
    if (op.cmd == CmdClear) begin
      for (int r = 0; r < MatrixSize; r++) model_rows[r] = '0;
    end else if (op.cmd == CmdWrite) begin
      model_rows[op.row][op.col] = op.cell_val;
    end else if (op.cmd == CmdQuery) begin
      col_span = covered_cells(op.rect.col_first, op.rect.col_last);
      row_span = covered_cells(op.rect.row_first, op.rect.row_last);
      flag = border_holds(model_rows[op.rect.row_first], col_span)
          && border_holds(model_rows[op.rect.row_last], col_span)
          && border_holds(column_word(op.rect.col_first), row_span)
          && border_holds(column_word(op.rect.col_last), row_span);
      awaited_flags = {awaited_flags, flag};
    end
  endtask

  // Fields a beat does not use still carry random values
  function automatic matrix_op_t random_op(logic [InTuserW-1:0] cmd);
    matrix_op_t op;
    op.cmd            = cmd;
    op.row            = idx_t'($urandom);
    op.col            = idx_t'($urandom);
    op.cell_val       = 1'($urandom);
    op.rect.row_first = idx_t'($urandom);
    op.rect.row_last  = idx_t'($urandom);
    op.rect.col_first = idx_t'($urandom);
    op.rect.col_last  = idx_t'($urandom);
    return op;
  endfunction

  task automatic queue_op(matrix_op_t op);
    op_queue = {op_queue, op};
    op_count++;
  endtask

  task automatic queue_write(idx_t r, idx_t c, logic v);
    matrix_op_t op;
    op          = random_op(CmdWrite);
    op.row      = r;
    op.col      = c;
    op.cell_val = v;
    queue_op(op);
  endtask

  task automatic queue_query(idx_t rf, idx_t rl, idx_t cf, idx_t cl);
    matrix_op_t op;
    op = random_op(CmdQuery);
    op.rect = '{row_first: rf, row_last: rl, col_first: cf, col_last: cl};
    queue_op(op);
  endtask

  // Build a rectangle whose borders mostly pass, then query it and sometimes a neighbour
  task automatic queue_rect_sequence();
    idx_t rf, rl, cf, cl, tmp;
    int   extra;
    if ($urandom_range(0, 3) != 0) queue_op(random_op(CmdClear));
    rf = idx_t'($urandom_range(0, MatrixSize - 1));
    rl = idx_t'($urandom_range(rf, MatrixSize - 1));
    cf = idx_t'($urandom_range(0, MatrixSize - 1));
    cl = idx_t'($urandom_range(cf, MatrixSize - 1));
    // corners on opposite ends satisfy all four borders
    if ($urandom_range(0, 1) != 0) begin
      queue_write(rf, cf, 1'b1);
      queue_write(rl, cl, 1'b1);
    end else begin
      queue_write(rl, cl, 1'b1);
      queue_write(rf, cf, 1'b1);
    end
    extra = $urandom_range(0, 4);
    for (int i = 0; i < extra; i++) begin
      queue_write(idx_t'($urandom_range(rf, rl)), idx_t'($urandom_range(cf, cl)),
                  1'($urandom));
    end
    // sometimes spoil a border with a stray cell anywhere
    if ($urandom_range(0, 3) == 0) queue_write(idx_t'($urandom), idx_t'($urandom), 1'b1);
    if ($urandom_range(0, 7) == 0) begin
      tmp = rf; rf = rl; rl = tmp;
    end
    if ($urandom_range(0, 7) == 0) begin
      tmp = cf; cf = cl; cl = tmp;
    end
    queue_query(rf, rl, cf, cl);
    if ($urandom_range(0, 1) != 0) begin
      case ($urandom_range(0, 3))
        0: rf = idx_t'($urandom);
        1: rl = idx_t'($urandom);
        2: cf = idx_t'($urandom);
        default: cl = idx_t'($urandom);
      endcase
      queue_query(rf, rl, cf, cl);
    end
  endtask

  // Drive the slave stream from the op queue; predict on each accepted beat
  always @(posedge clk_i) begin : drive_ops
    matrix_op_t next_op;
    logic       gap;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) apply_to_matrix(op_on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        gap = !quiet_window() && ($urandom_range(0, 99) < IdlePct);
        if (op_queue.size() != 0 && !gap) begin
          next_op = op_queue.pop_front();
          op_on_bus     <= next_op;
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= next_op.cmd;
          s_axis_tdata  <= {7'b0, next_op.rect.col_last, next_op.rect.col_first,
                            next_op.rect.row_last, next_op.rect.row_first,
                            next_op.cell_val, next_op.col, next_op.row};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check flag beats against the oldest expectation; stall the master side at random
  always @(posedge clk_i) begin : watch_flags
    logic want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_flags.size() == 0) begin
          $error("rect_valid beat with no query pending, actual %0b", m_axis_tdata[0]);
          fail_count++;
        end else begin
          want = awaited_flags.pop_front();
          if (m_axis_tdata[0] !== want) begin
            $error("rect_valid mismatch: expected %0b, actual %0b", want, m_axis_tdata[0]);
            fail_count++;
          end
        end
      end
      m_axis_tready <= quiet_window() || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  initial begin
    // Directed opening: empty matrix, corners, single cell, reversed spans, unused code
    queue_query(4'd0, 4'd15, 4'd0, 4'd15);
    queue_op('{cmd: CmdUnused, row: 4'hf, col: 4'hf, cell_val: 1'b1,
               rect: '{4'hf, 4'hf, 4'hf, 4'hf}});
    queue_query(4'd0, 4'd15, 4'd0, 4'd15);
    queue_write(4'd0, 4'd0, 1'b1);
    queue_write(4'd15, 4'd15, 1'b1);
    queue_query(4'd0, 4'd15, 4'd0, 4'd15);
    queue_query(4'd15, 4'd0, 4'd15, 4'd0);
    queue_query(4'd0, 4'd15, 4'd15, 4'd0);
    queue_query(4'd0, 4'd0, 4'd0, 4'd0);
    queue_query(4'd15, 4'd15, 4'd15, 4'd15);
    queue_write(4'd0, 4'd15, 1'b1);
    queue_query(4'd0, 4'd0, 4'd0, 4'd0);
    queue_query(4'd0, 4'd15, 4'd0, 4'd15);
    queue_write(4'd0, 4'd15, 1'b0);
    queue_query(4'd0, 4'd0, 4'd0, 4'd0);
    queue_op('{cmd: CmdWrite, row: 4'hf, col: 4'hf, cell_val: 1'b0,
               rect: '{4'hf, 4'hf, 4'hf, 4'hf}});
    queue_query(4'd15, 4'd15, 4'd15, 4'd15);
    queue_op('{cmd: CmdClear, row: 4'hf, col: 4'hf, cell_val: 1'b1,
               rect: '{4'hf, 4'hf, 4'hf, 4'hf}});
    queue_op('{cmd: CmdQuery, row: 4'hf, col: 4'hf, cell_val: 1'b1,
               rect: '{4'd0, 4'd0, 4'd0, 4'd0}});
    queue_write(4'd7, 4'd9, 1'b1);
    queue_query(4'd7, 4'd7, 4'd9, 4'd9);
    queue_query(4'd7, 4'd7, 4'd0, 4'd15);
    queue_query(4'd0, 4'd15, 4'd9, 4'd9);

    // Random part: mostly rectangle-building sequences, some noise
    while (op_count < NumItems) begin
      if ($urandom_range(0, 99) < 85) begin
        queue_rect_sequence();
      end else begin
        repeat ($urandom_range(1, 3)) queue_op(random_op(InTuserW'($urandom)));
      end
    end

    // Hold reset, then release
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain stimulus and outstanding flags
    while (op_queue.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (awaited_flags.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (m_axis_tvalid) begin
      $error("rect_valid beat offered after all queries were answered");
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
